/* rtl/core/rlad_pkg.sv */
// Package for the ring link admission and delay block.
// Holds widths, command and reject codes, and the word types. No dependencies.
package rlad_pkg;

  localparam int unsigned MaxRespLanes = 3;
  localparam int unsigned MaxCapacity  = 16;
  localparam int unsigned ReqHdrBytes  = 16;
  localparam int unsigned RspHdrBytes  = 16;
  localparam int unsigned MaxResults   = 64;

  typedef enum logic [1:0] {
    CmdTick   = 2'd0,
    CmdOffer  = 2'd1,
    CmdBubble = 2'd2,
    CmdNone   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    RejNone   = 2'd0,
    RejBusy   = 2'd1,
    RejFull   = 2'd2,
    RejBubble = 2'd3
  } reject_e;

  localparam logic [1:0] CfgLatency = 2'd0;
  localparam logic [1:0] CfgWidth   = 2'd1;
  localparam logic [1:0] CfgLanes   = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic        is_response;
    logic [2:0]  phys_lane;
    logic [2:0]  traffic_class;
    logic [12:0] payload_bytes;
    logic [15:0] packet_tag;
    logic [3:0]  dest_channel;
    logic [3:0]  downstream_ready;
  } in_word_t;

  typedef struct packed {
    logic        accepted;
    logic [1:0]  reject_reason;
    logic [12:0] serial_cycles;
    logic        delivered;
    logic [15:0] out_tag;
    logic [3:0]  out_channel;
    logic [1:0]  out_lane;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic [1:0] index;
    logic [6:0] data;
  } cfg_word_t;

  // Classified item passed from the front part to the back part.
  typedef struct packed {
    logic        is_tick;
    logic        is_offer;
    logic        bubble;
    logic [2:0]  lane;
    logic [12:0] bytes;
    logic [15:0] tag;
    logic [3:0]  channel;
    logic [3:0]  ready;
  } job_t;

endpackage

/* rtl/core/rlad_if.sv */
// Valid/ready stream interface carrying one word of a given type.
// No dependencies; the word type is a parameter of each instance.
interface rlad_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/ring_link_admission_delay.sv */
// Top level of the ring link admission and delay block.
// Depends on rlad_pkg, rlad_if, rlad_front and rlad_back.
//
// Channels: in_i carries one input word (tick or offer), out_o returns result
// words with last set on the final word of each input, and cfg_i writes the
// latency, width and lane count registers by index.
// An admitted offer is checked, then passes a restoring divider that yields
// one quotient bit per cycle, and then writes the delay queue. A refused
// offer is checked and its reject word is sent. A tick starts, visits each
// lane, examines queue entries through the registered read of the delay
// queue memory and finishes, with at most 64 words per tick.
// A two-entry queue between the classifying front and the executing back
// lets new words be taken while results wait in the output register.
// Reset clears time, sender times, counts and queue heads; queue memory is
// left as is since only written entries are read. When the receiver stalls
// the back part holds and the front queue fills, then in_i.ready drops.
module ring_link_admission_delay #(
  parameter int unsigned MaxRespLanesP = rlad_pkg::MaxRespLanes,
  parameter int unsigned MaxCapacityP  = rlad_pkg::MaxCapacity
) (
  input logic  clk_i,
  input logic  rst_ni,
  rlad_if.sink   in_i,
  rlad_if.sink   cfg_i,
  rlad_if.source out_o
);
  import rlad_pkg::*;

  logic [3:0] lat_q;
  logic [6:0] wid_q;
  logic [1:0] lanes_q;
  job_t       job;
  logic       job_valid, job_pop;

  // Configuration registers.
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lat_q   <= 4'd1;
      wid_q   <= 7'd16;
      lanes_q <= 2'd1;
    end else if (cfg_i.valid) begin
      if (cfg_i.data.index == CfgLatency) lat_q   <= cfg_i.data.data[3:0];
      if (cfg_i.data.index == CfgWidth)   wid_q   <= cfg_i.data.data;
      if (cfg_i.data.index == CfgLanes)   lanes_q <= cfg_i.data.data[1:0];
    end
  end

  rlad_front #(.MaxRespLanesP(MaxRespLanesP)) u_front (
    .clk_i, .rst_ni, .lanes_cfg_i(lanes_q), .in_i,
    .job_o(job), .job_valid_o(job_valid), .job_pop_i(job_pop)
  );

  rlad_back #(.MaxRespLanesP(MaxRespLanesP), .MaxCapacityP(MaxCapacityP)) u_back (
    .clk_i, .rst_ni, .latency_i(lat_q), .width_i(wid_q),
    .job_i(job), .job_valid_i(job_valid), .job_pop_o(job_pop), .out_o
  );

  // An offer result never reports delivery.
  a_offer_no_dlv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.data.accepted |-> !out_o.data.delivered)
    else $error("accepted and delivered together");
  // A refused offer charges nothing.
  a_rej_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.data.reject_reason != RejNone |-> out_o.data.serial_cycles == '0)
    else $error("refused offer charged cycles");
  // Accepted offers always charge a nonzero serialization count.
  a_ser_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.data.accepted |-> out_o.data.serial_cycles != '0)
    else $error("zero serialization");
endmodule

/* rtl/core/rlad_ram.sv */
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module rlad_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* rtl/core/rlad_front.sv */
// Front part: accepts input words, maps offers to a lane and queues jobs.
// Depends on rlad_pkg and rlad_if.
module rlad_front #(
  parameter int unsigned MaxRespLanesP = rlad_pkg::MaxRespLanes
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [1:0]          lanes_cfg_i,
  rlad_if.sink                in_i,
  output rlad_pkg::job_t      job_o,
  output logic                job_valid_o,
  input  logic                job_pop_i
);
  import rlad_pkg::*;

  localparam int unsigned Depth = 2;

  job_t       fifo_q [Depth];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  job_t       job_d;
  logic [2:0] lanes_use, rem;
  logic       push;

  // Effective response lane count, and phys_lane modulo it (small values).
  always_comb begin
    lanes_use = {1'b0, lanes_cfg_i};
    if (lanes_use == 3'd0) lanes_use = 3'd1;
    if (lanes_use > 3'(MaxRespLanesP)) lanes_use = 3'(MaxRespLanesP);
    rem = in_i.data.phys_lane;
    if (rem >= lanes_use) rem = rem - lanes_use;
    if (rem >= lanes_use) rem = rem - lanes_use;
    if (rem >= lanes_use) rem = rem - lanes_use;
    if (rem >= lanes_use) rem = rem - lanes_use;
    if (rem >= lanes_use) rem = rem - lanes_use;
    if (rem >= lanes_use) rem = rem - lanes_use;
    if (rem >= lanes_use) rem = rem - lanes_use;
  end

  // Classify the word.
  always_comb begin
    job_d          = '0;
    job_d.is_tick  = (in_i.data.command == CmdTick);
    job_d.is_offer = (in_i.data.command == CmdOffer) || (in_i.data.command == CmdBubble);
    job_d.bubble   = (in_i.data.command == CmdBubble);
    job_d.lane     = in_i.data.is_response ? rem + 3'd1 : 3'd0;
    unique case (in_i.data.traffic_class)
      3'd0, 3'd1: job_d.bytes = 13'(ReqHdrBytes);
      3'd3, 3'd4: job_d.bytes = 13'(RspHdrBytes);
      default:    job_d.bytes = in_i.data.payload_bytes;
    endcase
    job_d.tag     = in_i.data.packet_tag;
    job_d.channel = in_i.data.dest_channel;
    job_d.ready   = in_i.data.downstream_ready;
  end

  assign in_i.ready  = (cnt_q != 2'(Depth));
  assign push        = in_i.valid && in_i.ready;
  assign job_valid_o = (cnt_q != 2'd0);
  assign job_o       = fifo_q[rp_q];

  // Short queue to the back part.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (job_pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(job_pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wp_q] <= job_d;
  end
endmodule

/* rtl/core/rlad_back.sv */
// Back part: admission checks, serialization divide, delay queues and drain.
// Depends on rlad_pkg, rlad_if and rlad_ram.
module rlad_back #(
  parameter int unsigned MaxRespLanesP = rlad_pkg::MaxRespLanes,
  parameter int unsigned MaxCapacityP  = rlad_pkg::MaxCapacity
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [3:0]     latency_i,
  input  logic [6:0]     width_i,
  input  rlad_pkg::job_t job_i,
  input  logic           job_valid_i,
  output logic           job_pop_o,
  rlad_if.source         out_o
);
  import rlad_pkg::*;

  localparam int unsigned NLanes = MaxRespLanesP + 1;
  localparam int unsigned LaneW  = $clog2(NLanes);
  localparam int unsigned SlotW  = (MaxCapacityP > 1) ? $clog2(MaxCapacityP) : 1;
  localparam int unsigned CntW   = $clog2(MaxCapacityP + 1);
  localparam int unsigned AddrW  = LaneW + SlotW;
  localparam int unsigned EntW   = 52;

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StDiv   = 4'd1;
  localparam logic [3:0] StOffer = 4'd2;
  localparam logic [3:0] StLane  = 4'd3;
  localparam logic [3:0] StRead  = 4'd4;
  localparam logic [3:0] StChk   = 4'd5;
  localparam logic [3:0] StEmpty = 4'd6;
  localparam logic [3:0] StFlush = 4'd7;
  localparam logic [3:0] StWait  = 4'd8;

  logic [3:0]        st_q, st_d;
  logic [31:0]       time_q;
  logic [31:0]       nst_q  [NLanes];
  logic [CntW-1:0]   cnt_q  [NLanes];
  logic [SlotW-1:0]  head_q [NLanes];
  logic [LaneW-1:0]  lane_q;
  logic [6:0]        nres_q;
  logic [12:0]       quo_q, rem_q;
  logic [13:0]       dvd_q;
  logic [3:0]        bit_q;
  logic [6:0]        wid;
  out_word_t         obuf_q, pend_q;
  logic              obuf_v_q, pend_v_q;
  logic              we;
  logic [AddrW-1:0]  waddr, raddr;
  logic [EntW-1:0]   wdata, rdata;
  logic [LaneW-1:0]  olane;
  logic [31:0]       diff;
  logic [CntW:0]     cap;
  logic [13:0]       trial;
  logic [12:0]       ser;
  logic              busy, arrived;

  assign olane = job_i.lane[LaneW-1:0];
  assign wid   = (width_i == 7'd0) ? 7'd1 : width_i;
  assign diff  = nst_q[olane] - time_q;
  assign busy  = (diff >= 32'd1) && (diff <= 32'd8191);
  always_comb begin
    cap = (CntW+1)'(latency_i) + 1'b1;
    if (cap > (CntW+1)'(MaxCapacityP)) cap = (CntW+1)'(MaxCapacityP);
  end
  // Restoring divide of bytes + wid - 1 by wid, one quotient bit per cycle.
  // The dividend needs 14 bits since the byte count can reach 8191.
  assign trial = {rem_q, dvd_q[13]} - {7'd0, wid};
  assign ser   = (quo_q == 13'd0) ? 13'd1 : quo_q;

  assign we    = (st_q == StOffer) && !obuf_v_q;
  assign waddr = {olane, SlotW'(head_q[olane] + SlotW'(cnt_q[olane]))};
  assign wdata = {time_q + 32'(latency_i), job_i.channel, job_i.tag};
  assign raddr = {lane_q, head_q[lane_q]};
  assign arrived = ((time_q - rdata[51:20]) < 32'h8000_0000);

  rlad_ram #(.Width(EntW), .Depth(NLanes * (1 << SlotW))) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  assign out_o.valid = obuf_v_q;
  assign out_o.data  = obuf_q;
  assign job_pop_o   = (st_q == StWait) ||
                       (st_q == StOffer && !obuf_v_q) ||
                       (st_q == StIdle && job_valid_i && !job_i.is_tick &&
                        !job_i.is_offer && !obuf_v_q);

  // Sequencer with output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= StIdle;
      time_q   <= '0;
      obuf_v_q <= 1'b0;
      pend_v_q <= 1'b0;
      lane_q   <= '0;
      nres_q   <= '0;
      for (int i = 0; i < NLanes; i++) begin
        nst_q[i]  <= '0;
        cnt_q[i]  <= '0;
        head_q[i] <= '0;
      end
    end else begin
      if (out_o.valid && out_o.ready) obuf_v_q <= 1'b0;
      unique case (st_q)
        StIdle: if (job_valid_i) begin
          if (job_i.is_tick) begin
            time_q   <= time_q + 32'd1;
            lane_q   <= '0;
            nres_q   <= '0;
            pend_v_q <= 1'b0;
            st_q     <= StLane;
          end else if (job_i.is_offer) begin
            if (busy || cnt_q[olane] >= CntW'(cap) ||
                (job_i.bubble && cap > 1 && (CntW+1)'(cnt_q[olane]) + 1'b1 >= cap)) begin
              pend_q <= '0;
              pend_q.reject_reason <= busy ? RejBusy :
                (cnt_q[olane] >= CntW'(cap)) ? RejFull : RejBubble;
              pend_q.out_lane <= 2'(olane);
              pend_q.last <= 1'b1;
              st_q <= StFlush;
            end else begin
              quo_q <= '0; rem_q <= '0;
              dvd_q <= 14'(job_i.bytes) + 14'(wid) - 14'd1;
              bit_q <= 4'd13;
              st_q  <= StDiv;
            end
          end else if (!obuf_v_q) begin
            obuf_q      <= '0;
            obuf_q.last <= 1'b1;
            obuf_v_q    <= 1'b1;
          end
        end
        StDiv: begin
          if (!trial[13]) begin
            rem_q <= trial[12:0];
            quo_q <= {quo_q[11:0], 1'b1};
          end else begin
            rem_q <= {rem_q[11:0], dvd_q[13]};
            quo_q <= {quo_q[11:0], 1'b0};
          end
          dvd_q <= {dvd_q[12:0], 1'b0};
          bit_q <= bit_q - 4'd1;
          if (bit_q == 4'd0) st_q <= StOffer;
        end
        StOffer: if (!obuf_v_q) begin
          cnt_q[olane] <= cnt_q[olane] + 1'b1;
          nst_q[olane] <= time_q + 32'(ser);
          obuf_q <= '0;
          obuf_q.accepted <= 1'b1;
          obuf_q.serial_cycles <= ser;
          obuf_q.out_lane <= 2'(olane);
          obuf_q.last <= 1'b1;
          obuf_v_q <= 1'b1;
          st_q <= StIdle;
        end
        StLane: begin
          if ((32'(lane_q) < 32'd4) && job_i.ready[lane_q[1:0]] &&
              cnt_q[lane_q] != '0 && nres_q < 7'(MaxResults)) begin
            st_q <= StRead;
          end else if (32'(lane_q) == 32'(NLanes - 1)) begin
            st_q <= pend_v_q ? StFlush : StEmpty;
          end else begin
            lane_q <= lane_q + 1'b1;
          end
        end
        StRead: st_q <= StChk;
        StChk: begin
          if (!arrived) begin
            if (32'(lane_q) == 32'(NLanes - 1)) st_q <= pend_v_q ? StFlush : StEmpty;
            else begin lane_q <= lane_q + 1'b1; st_q <= StLane; end
          end else if (!pend_v_q || !obuf_v_q || (out_o.valid && out_o.ready)) begin
            // Hold one delivery so the last flag can be set on the final one.
            if (pend_v_q) begin obuf_q <= pend_q; obuf_v_q <= 1'b1; end
            pend_q <= '0;
            pend_q.delivered <= 1'b1;
            pend_q.out_tag <= rdata[15:0];
            pend_q.out_channel <= rdata[19:16];
            pend_q.out_lane <= 2'(lane_q);
            pend_v_q <= 1'b1;
            nres_q <= nres_q + 7'd1;
            head_q[lane_q] <= head_q[lane_q] + 1'b1;
            cnt_q[lane_q]  <= cnt_q[lane_q] - 1'b1;
            st_q <= StLane;
          end
        end
        StEmpty: if (!obuf_v_q) begin
          obuf_q <= '0;
          obuf_q.last <= 1'b1;
          obuf_v_q <= 1'b1;
          st_q <= StWait;
        end
        StFlush: if (!obuf_v_q) begin
          obuf_q <= pend_q;
          obuf_q.last <= 1'b1;
          obuf_v_q <= 1'b1;
          pend_v_q <= 1'b0;
          st_q <= StWait;
        end
        StWait: st_q <= StIdle;
        default: st_q <= StIdle;
      endcase
    end
  end
endmodule
